// ===== rtl/ssid_pkg.sv =====
// Shared types and constants for the sorted segment insert/delete block.
// No dependencies; imported by the cell, the top level and the testbench.
package ssid_pkg;

   localparam int SSID_WORD_BITS = 64;
   // wide enough for a slot position up to 127
   localparam int SSID_POS_BITS  = 7;

   localparam logic [SSID_WORD_BITS-1:0] SSID_EMPTY_MARK = {1'b1, {(SSID_WORD_BITS-1){1'b0}}};

   // request modes
   localparam logic [1:0] SSID_MODE_LOAD   = 2'd0;
   localparam logic [1:0] SSID_MODE_READ   = 2'd1;
   localparam logic [1:0] SSID_MODE_INSERT = 2'd2;
   localparam logic [1:0] SSID_MODE_DELETE = 2'd3;

   // response status codes
   localparam logic [1:0] SSID_ST_OK      = 2'd0;
   localparam logic [1:0] SSID_ST_ABSENT  = 2'd1;
   localparam logic [1:0] SSID_ST_DROPPED = 2'd2;
   localparam logic [1:0] SSID_ST_RANGE   = 2'd3;

   // control broadcast from the sequencer to every cell of the chain
   typedef struct packed {
      logic                      shift;  // take the right neighbor's word
      logic                      ins;    // open a slot at pos and place key there
      logic                      del;    // close the slot at pos
      logic [SSID_WORD_BITS-1:0] key;
      logic [SSID_POS_BITS-1:0]  pos;
   } cell_ctrl_type;

endpackage

// ===== rtl/sorted_segment_insert_delete.sv =====
// Sorted segment insert/delete engine: word memory plus a chain of segment cells.
// Depends on ssid_pkg, ssid_ram and ssid_cell.
//
// Usage:
//   The request channel (req_valid/req_stall) carries a mode, an address and a
//   64-bit value. Load writes the value at the address; read returns the word
//   there; insert and delete edit the sorted segment that starts at the head
//   address. Every request gives exactly one response word on the rsp_ channel
//   with read data (zero unless a read) and a status code.
//   The segment of an insert or delete streams out of the single read port into
//   the cell chain one word a cycle, is edited in place, then streams back
//   through the write port. A delete of an absent value skips the write-back.
//   One request is in flight at a time; req_stall is high from acceptance until
//   the response has moved into the output register, so the next request is
//   taken in the cycle after that.
//   A stalled response holds in the output register; the engine waits with its
//   finished result until that register frees up.
//   Reset clears the control state only; memory words are undefined until written.
module sorted_segment_insert_delete #(
   parameter int SEGMENT_WORDS = 16,
   parameter int MEMORY_WORDS  = 4096
) (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_valid,
   output logic        req_stall,
   input  logic [1:0]  req_mode,
   input  logic [11:0] req_address,
   input  logic [63:0] req_value,
   output logic        rsp_valid,
   input  logic        rsp_stall,
   output logic [63:0] rsp_read_data,
   output logic [1:0]  rsp_status
);
   import ssid_pkg::*;

   localparam int AW    = $clog2(MEMORY_WORDS);
   localparam int POS_W = $clog2(SEGMENT_WORDS + 1);
   localparam int CHK_W = ((AW > 12) ? AW : 12) + 1;

   localparam logic [2:0] ST_IDLE  = 3'd0;
   localparam logic [2:0] ST_READ  = 3'd1;
   localparam logic [2:0] ST_FILL  = 3'd2;
   localparam logic [2:0] ST_EDIT  = 3'd3;
   localparam logic [2:0] ST_DRAIN = 3'd4;
   localparam logic [2:0] ST_DONE  = 3'd5;

   logic [2:0]                state_ff, state_in;
   logic [AW-1:0]             head_ff, head_in;
   logic [SSID_WORD_BITS-1:0] key_ff, key_in;
   logic                      insert_ff, insert_in;
   logic [POS_W-1:0]          cnt_ff, cnt_in;
   logic [POS_W-1:0]          below_ff, below_in;
   logic [POS_W-1:0]          match_ff, match_in;
   logic                      found_ff, found_in;
   logic [SSID_WORD_BITS-1:0] result_data_ff, result_data_in;
   logic [1:0]                result_status_ff, result_status_in;
   logic                      rsp_valid_ff, rsp_valid_in;
   logic [SSID_WORD_BITS-1:0] rsp_read_data_ff, rsp_read_data_in;
   logic [1:0]                rsp_status_ff, rsp_status_in;

   logic                      req_accept;
   logic                      out_free;
   logic [CHK_W-1:0]          addr_ext;
   logic                      addr_bad;
   logic                      head_bad;
   logic [AW-1:0]             seg_addr;
   logic                      ram_wr_en;
   logic [AW-1:0]             ram_wr_addr;
   logic [SSID_WORD_BITS-1:0] ram_wr_data;
   logic                      ram_rd_en;
   logic [AW-1:0]             ram_rd_addr;
   logic [SSID_WORD_BITS-1:0] ram_rd_data;
   logic [SSID_WORD_BITS-1:0] tail_word;
   logic [SSID_WORD_BITS-1:0] dropped_word;
   cell_ctrl_type             ctrl;
   logic [SSID_WORD_BITS-1:0] cell_word [SEGMENT_WORDS];

   assign req_accept = req_valid && !req_stall;
   assign req_stall  = (state_ff != ST_IDLE);
   assign out_free   = !rsp_valid_ff || !rsp_stall;

   // range checks on the incoming address
   assign addr_ext = CHK_W'(req_address);
   assign addr_bad = (addr_ext >= CHK_W'(MEMORY_WORDS));
   assign head_bad = ((addr_ext + CHK_W'(SEGMENT_WORDS)) > CHK_W'(MEMORY_WORDS));
   assign seg_addr = head_ff + AW'(cnt_ff);

   // word memory
   ssid_ram #(
      .WIDTH (SSID_WORD_BITS),
      .DEPTH (MEMORY_WORDS)
   ) u_ram (
      .clock   (clock),
      .wr_en   (ram_wr_en),
      .wr_addr (ram_wr_addr),
      .wr_data (ram_wr_data),
      .rd_en   (ram_rd_en),
      .rd_addr (ram_rd_addr),
      .rd_data (ram_rd_data)
   );

   // memory port steering: single-word access in idle, segment sweeps otherwise
   always_comb begin
      ram_wr_en   = 1'b0;
      ram_wr_addr = seg_addr;
      ram_wr_data = cell_word[0];
      ram_rd_en   = 1'b0;
      ram_rd_addr = seg_addr;
      if (state_ff == ST_IDLE) begin
         ram_wr_addr = addr_ext[AW-1:0];
         ram_wr_data = req_value;
         ram_rd_addr = addr_ext[AW-1:0];
         ram_wr_en   = req_accept && (req_mode == SSID_MODE_LOAD) && !addr_bad;
         ram_rd_en   = req_accept && (req_mode == SSID_MODE_READ) && !addr_bad;
      end else if (state_ff == ST_FILL) begin
         ram_rd_en = (cnt_ff < POS_W'(SEGMENT_WORDS));
      end else if (state_ff == ST_DRAIN) begin
         ram_wr_en = 1'b1;
      end
   end

   // cell chain control
   assign tail_word = (state_ff == ST_FILL) ? ram_rd_data : SSID_EMPTY_MARK;

   always_comb begin
      ctrl.shift = ((state_ff == ST_FILL) && (cnt_ff != '0)) || (state_ff == ST_DRAIN);
      ctrl.ins   = (state_ff == ST_EDIT) && insert_ff;
      ctrl.del   = (state_ff == ST_EDIT) && !insert_ff && found_ff;
      ctrl.key   = key_ff;
      ctrl.pos   = insert_ff ? SSID_POS_BITS'(below_ff) : SSID_POS_BITS'(match_ff);
   end

   for (genvar gi = 0; gi < SEGMENT_WORDS; gi++) begin : g_cell
      logic [SSID_WORD_BITS-1:0] left_word;
      logic [SSID_WORD_BITS-1:0] right_word;
      if (gi == 0) begin : g_head
         assign left_word = key_ff;
      end else begin : g_mid
         assign left_word = cell_word[gi-1];
      end
      if (gi == SEGMENT_WORDS - 1) begin : g_tail
         assign right_word = tail_word;
      end else begin : g_body
         assign right_word = cell_word[gi+1];
      end
      ssid_cell u_cell (
         .clock      (clock),
         .ctrl       (ctrl),
         .cell_index (SSID_POS_BITS'(gi)),
         .left_word  (left_word),
         .right_word (right_word),
         .word       (cell_word[gi])
      );
   end

   // word an insert drops: the last slot's word, or the key if it sorts past the end
   assign dropped_word = (below_ff == POS_W'(SEGMENT_WORDS)) ? key_ff
                                                             : cell_word[SEGMENT_WORDS-1];

   // sequencer
   always_comb begin
      state_in         = state_ff;
      head_in          = head_ff;
      key_in           = key_ff;
      insert_in        = insert_ff;
      cnt_in           = cnt_ff;
      below_in         = below_ff;
      match_in         = match_ff;
      found_in         = found_ff;
      result_data_in   = result_data_ff;
      result_status_in = result_status_ff;
      rsp_valid_in     = rsp_valid_ff && rsp_stall;
      rsp_read_data_in = rsp_read_data_ff;
      rsp_status_in    = rsp_status_ff;
      unique case (state_ff)
         ST_IDLE: begin
            if (req_accept) begin
               head_in          = addr_ext[AW-1:0];
               key_in           = {1'b0, req_value[SSID_WORD_BITS-2:0]};
               insert_in        = (req_mode == SSID_MODE_INSERT);
               cnt_in           = '0;
               below_in         = '0;
               match_in         = '0;
               found_in         = 1'b0;
               result_data_in   = '0;
               result_status_in = SSID_ST_OK;
               if ((req_mode == SSID_MODE_LOAD) || (req_mode == SSID_MODE_READ)) begin
                  if (addr_bad) begin
                     result_status_in = SSID_ST_RANGE;
                     state_in         = ST_DONE;
                  end else if (req_mode == SSID_MODE_READ) begin
                     state_in = ST_READ;
                  end else begin
                     state_in = ST_DONE;
                  end
               end else if (head_bad) begin
                  result_status_in = SSID_ST_RANGE;
                  state_in         = ST_DONE;
               end else begin
                  state_in = ST_FILL;
               end
            end
         end
         ST_READ: begin
            result_data_in = ram_rd_data;
            state_in       = ST_DONE;
         end
         ST_FILL: begin
            // score each arriving word against the key
            if (cnt_ff != '0) begin
               if (ram_rd_data < key_ff) begin
                  below_in = below_ff + 1'b1;
               end
               if (ram_rd_data == key_ff) begin
                  found_in = 1'b1;
                  match_in = cnt_ff - 1'b1;
               end
            end
            if (cnt_ff == POS_W'(SEGMENT_WORDS)) begin
               cnt_in   = '0;
               state_in = ST_EDIT;
            end else begin
               cnt_in = cnt_ff + 1'b1;
            end
         end
         ST_EDIT: begin
            if (insert_ff) begin
               result_status_in = (dropped_word != SSID_EMPTY_MARK) ? SSID_ST_DROPPED
                                                                    : SSID_ST_OK;
               state_in         = ST_DRAIN;
            end else if (found_ff) begin
               state_in = ST_DRAIN;
            end else begin
               result_status_in = SSID_ST_ABSENT;
               state_in         = ST_DONE;
            end
         end
         ST_DRAIN: begin
            // write the edited segment back, one word a cycle
            if (cnt_ff == POS_W'(SEGMENT_WORDS - 1)) begin
               cnt_in   = '0;
               state_in = ST_DONE;
            end else begin
               cnt_in = cnt_ff + 1'b1;
            end
         end
         ST_DONE: begin
            if (out_free) begin
               rsp_valid_in     = 1'b1;
               rsp_read_data_in = result_data_ff;
               rsp_status_in    = result_status_ff;
               state_in         = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   // control registers
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   // payload registers
   always_ff @(posedge clock) begin
      head_ff          <= head_in;
      key_ff           <= key_in;
      insert_ff        <= insert_in;
      cnt_ff           <= cnt_in;
      below_ff         <= below_in;
      match_ff         <= match_in;
      found_ff         <= found_in;
      result_data_ff   <= result_data_in;
      result_status_ff <= result_status_in;
      rsp_read_data_ff <= rsp_read_data_in;
      rsp_status_ff    <= rsp_status_in;
   end

   assign rsp_valid     = rsp_valid_ff;
   assign rsp_read_data = rsp_read_data_ff;
   assign rsp_status    = rsp_status_ff;

endmodule

// ===== rtl/ssid_ram.sv =====
// Generic single-port-write, single-port-read RAM with registered read data.
// No dependencies; holds the segment word memory.
module ssid_ram #(
   parameter int WIDTH = 64,
   parameter int DEPTH = 4096
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(DEPTH)-1:0] wr_addr,
   input  logic [WIDTH-1:0]         wr_data,
   input  logic                     rd_en,
   input  logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   // write port
   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
   end

   // registered read port, hold data between reads
   always_ff @(posedge clock) begin
      if (rd_en) begin
         rd_data_ff <= mem_ff[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

// ===== rtl/ssid_cell.sv =====
// One slot of the segment working buffer: holds a word, shifts toward the head,
// and opens or closes its slot on an insert or delete edit. Depends on ssid_pkg.
module ssid_cell (
   input  logic                                   clock,
   input  ssid_pkg::cell_ctrl_type                ctrl,
   input  logic [ssid_pkg::SSID_POS_BITS-1:0]     cell_index,
   input  logic [ssid_pkg::SSID_WORD_BITS-1:0]    left_word,
   input  logic [ssid_pkg::SSID_WORD_BITS-1:0]    right_word,
   output logic [ssid_pkg::SSID_WORD_BITS-1:0]    word
);
   import ssid_pkg::*;

   logic [SSID_WORD_BITS-1:0] word_ff;
   logic [SSID_WORD_BITS-1:0] word_in;

   // pick the next word: shift, insert edit, delete edit or hold
   always_comb begin
      word_in = word_ff;
      priority if (ctrl.shift) begin
         word_in = right_word;
      end else if (ctrl.ins) begin
         if (cell_index == ctrl.pos) begin
            word_in = ctrl.key;
         end else if (cell_index > ctrl.pos) begin
            word_in = left_word;
         end
      end else if (ctrl.del) begin
         if (cell_index >= ctrl.pos) begin
            word_in = right_word;
         end
      end else begin
         word_in = word_ff;
      end
   end

   always_ff @(posedge clock) begin
      word_ff <= word_in;
   end

   assign word = word_ff;

endmodule

// ===== verif/tb_sorted_segment_insert_delete.sv =====
// Testbench for sorted_segment_insert_delete: directed table, then random segment traffic.
// Depends on ssid_pkg and the RTL top level; checks responses against table rows or a predictor.
`timescale 1ns / 1ps

module tb_sorted_segment_insert_delete;
   import ssid_pkg::*;

   localparam int SEG_WORDS   = 16;
   localparam int MEM_WORDS   = 4096;
   localparam int ITEM_TARGET = 1450;
   localparam int QUIET_FROM  = 1250;
   localparam int HOLD_AT     = 400;
   localparam int HOLD_CYCLES = 300;
   localparam int DRAIN_AT    = 800;
   localparam int CYCLE_LIMIT = 1000000;
   localparam logic [63:0] ALL_ONES = '1;
   localparam logic [63:0] MAX_KEY  = 64'h7FFF_FFFF_FFFF_FFFF;

   typedef struct packed {
      logic [63:0] read_data;
      logic [1:0]  status;
   } rsp_word_type;

   typedef struct packed {
      logic [1:0]  mode;
      logic [11:0] addr;
      logic [63:0] value;
      bit          typed;
      logic [63:0] exp_data;
      logic [1:0]  exp_status;
   } stim_row_type;

   logic        clock = 1'b0;
   logic        reset = 1'b1;
   logic        req_valid = 1'b0;
   logic        req_stall;
   logic [1:0]  req_mode = SSID_MODE_LOAD;
   logic [11:0] req_address = '0;
   logic [63:0] req_value = '0;
   logic        rsp_valid;
   logic        rsp_stall = 1'b0;
   logic [63:0] rsp_read_data;
   logic [1:0]  rsp_status;

   // memory image and written map kept by the predictor
   logic [63:0]  mem_image [MEM_WORDS];
   bit           written [MEM_WORDS];
   int           seg_heads [$];
   rsp_word_type expected_rsp [$];
   int           sent_count = 0;
   int           error_count = 0;
   int           cycle_count = 0;
   bit           quiet = 1'b0;

   // directed rows: extremes, range errors, drop, duplicates, absent delete, max key
   stim_row_type directed_rows [26] = '{
      '{SSID_MODE_LOAD,   12'd0,    64'd0,           1'b1, 64'd0,    SSID_ST_OK},
      '{SSID_MODE_LOAD,   12'd4095, ALL_ONES,        1'b1, 64'd0,    SSID_ST_OK},
      '{SSID_MODE_READ,   12'd4095, 64'd0,           1'b1, ALL_ONES, SSID_ST_OK},
      '{SSID_MODE_READ,   12'd0,    ALL_ONES,        1'b1, 64'd0,    SSID_ST_OK},
      '{SSID_MODE_INSERT, 12'd4081, 64'd1,           1'b1, 64'd0,    SSID_ST_RANGE},
      '{SSID_MODE_DELETE, 12'd4095, ALL_ONES,        1'b1, 64'd0,    SSID_ST_RANGE},
      '{SSID_MODE_LOAD,   12'd4080, SSID_EMPTY_MARK, 1'b1, 64'd0,    SSID_ST_OK},
      '{SSID_MODE_LOAD,   12'd4081, SSID_EMPTY_MARK, 1'b1, 64'd0,    SSID_ST_OK},
      '{SSID_MODE_LOAD,   12'd4082, SSID_EMPTY_MARK, 1'b1, 64'd0,    SSID_ST_OK},
      '{SSID_MODE_LOAD,   12'd4083, SSID_EMPTY_MARK, 1'b1, 64'd0,    SSID_ST_OK},
      '{SSID_MODE_LOAD,   12'd4084, SSID_EMPTY_MARK, 1'b1, 64'd0,    SSID_ST_OK},
      '{SSID_MODE_LOAD,   12'd4085, SSID_EMPTY_MARK, 1'b1, 64'd0,    SSID_ST_OK},
      '{SSID_MODE_LOAD,   12'd4086, SSID_EMPTY_MARK, 1'b1, 64'd0,    SSID_ST_OK},
      '{SSID_MODE_LOAD,   12'd4087, SSID_EMPTY_MARK, 1'b1, 64'd0,    SSID_ST_OK},
      '{SSID_MODE_LOAD,   12'd4088, SSID_EMPTY_MARK, 1'b1, 64'd0,    SSID_ST_OK},
      '{SSID_MODE_LOAD,   12'd4089, SSID_EMPTY_MARK, 1'b1, 64'd0,    SSID_ST_OK},
      '{SSID_MODE_LOAD,   12'd4090, SSID_EMPTY_MARK, 1'b1, 64'd0,    SSID_ST_OK},
      '{SSID_MODE_LOAD,   12'd4091, SSID_EMPTY_MARK, 1'b1, 64'd0,    SSID_ST_OK},
      '{SSID_MODE_LOAD,   12'd4092, SSID_EMPTY_MARK, 1'b1, 64'd0,    SSID_ST_OK},
      '{SSID_MODE_LOAD,   12'd4093, SSID_EMPTY_MARK, 1'b1, 64'd0,    SSID_ST_OK},
      '{SSID_MODE_LOAD,   12'd4094, SSID_EMPTY_MARK, 1'b1, 64'd0,    SSID_ST_OK},
      // all-ones word in the last slot is a real entry and gets pushed out
      '{SSID_MODE_INSERT, 12'd4080, 64'd5,           1'b0, 64'd0,    SSID_ST_OK},
      // same key with bit 63 set: bit 63 is ignored, duplicate goes in
      '{SSID_MODE_INSERT, 12'd4080, SSID_EMPTY_MARK | 64'd5, 1'b0, 64'd0, SSID_ST_OK},
      '{SSID_MODE_DELETE, 12'd4080, 64'd5,           1'b0, 64'd0,    SSID_ST_OK},
      '{SSID_MODE_DELETE, 12'd4080, 64'd7,           1'b1, 64'd0,    SSID_ST_ABSENT},
      '{SSID_MODE_INSERT, 12'd4080, MAX_KEY,         1'b0, 64'd0,    SSID_ST_OK}
   };

   sorted_segment_insert_delete #(
      .SEGMENT_WORDS(SEG_WORDS),
      .MEMORY_WORDS (MEM_WORDS)
   ) u_top (
      .clock        (clock),
      .reset        (reset),
      .req_valid    (req_valid),
      .req_stall    (req_stall),
      .req_mode     (req_mode),
      .req_address  (req_address),
      .req_value    (req_value),
      .rsp_valid    (rsp_valid),
      .rsp_stall    (rsp_stall),
      .rsp_read_data(rsp_read_data),
      .rsp_status   (rsp_status)
   );

   initial begin
      forever #5 clock = ~clock;
   end

   // compute the response of one request and update the memory image
   function automatic rsp_word_type segment_update(input logic [1:0] mode,
                                                   input logic [11:0] addr,
                                                   input logic [63:0] value);
      rsp_word_type r;
      logic [63:0]  seg [SEG_WORDS];
      logic [63:0]  key;
      logic [63:0]  carry;
      logic [63:0]  t;
      int           below;
      int           pos;
      bit           found;
      r.read_data = '0;
      r.status    = SSID_ST_OK;
      if (mode == SSID_MODE_LOAD || mode == SSID_MODE_READ) begin
         if (int'(addr) >= MEM_WORDS) begin
            r.status = SSID_ST_RANGE;
         end else if (mode == SSID_MODE_LOAD) begin
            mem_image[addr] = value;
            written[addr]   = 1'b1;
         end else begin
            r.read_data = mem_image[addr];
         end
      end else if (int'(addr) + SEG_WORDS > MEM_WORDS) begin
         r.status = SSID_ST_RANGE;
      end else begin
         key = value & ~SSID_EMPTY_MARK;
         for (int i = 0; i < SEG_WORDS; i++) seg[i] = mem_image[int'(addr) + i];
         if (mode == SSID_MODE_INSERT) begin
            // open the slot at the count of words below the key, push the rest up
            below = 0;
            for (int i = 0; i < SEG_WORDS; i++) if (seg[i] < key) below++;
            carry = key;
            for (int i = 0; i < SEG_WORDS; i++) begin
               if (i >= below) begin
                  t      = seg[i];
                  seg[i] = carry;
                  carry  = t;
               end
            end
            if (carry != SSID_EMPTY_MARK) r.status = SSID_ST_DROPPED;
            for (int i = 0; i < SEG_WORDS; i++) mem_image[int'(addr) + i] = seg[i];
         end else begin
            // remove the highest matching slot, close the gap, refill the tail
            found = 1'b0;
            pos   = 0;
            for (int i = 0; i < SEG_WORDS; i++) begin
               if (seg[i] == key) begin
                  found = 1'b1;
                  pos   = i;
               end
            end
            if (!found) begin
               r.status = SSID_ST_ABSENT;
            end else begin
               for (int i = pos; i + 1 < SEG_WORDS; i++) seg[i] = seg[i + 1];
               seg[SEG_WORDS - 1] = SSID_EMPTY_MARK;
               for (int i = 0; i < SEG_WORDS; i++) mem_image[int'(addr) + i] = seg[i];
            end
         end
      end
      return r;
   endfunction

   function automatic bit segment_written(input int head);
      for (int i = 0; i < SEG_WORDS; i++) if (!written[head + i]) return 1'b0;
      return 1'b1;
   endfunction

   // pick a known segment, sometimes slid off its head to an unaligned start
   function automatic int pick_head();
      int h;
      int cand;
      h = seg_heads[$urandom_range(0, seg_heads.size() - 1)];
      if ($urandom_range(0, 3) == 0) begin
         cand = h + int'($urandom_range(0, 30)) - 15;
         if (cand >= 0 && cand + SEG_WORDS <= MEM_WORDS && segment_written(cand)) h = cand;
      end
      return h;
   endfunction

   // keys favor a small range so duplicates and hits are common
   function automatic logic [63:0] random_key();
      logic [63:0] k;
      case ($urandom_range(0, 9))
         0:          k = MAX_KEY;
         1, 2, 3, 4: k = 64'($urandom_range(0, 40));
         default:    k = {$urandom(), $urandom()} & ~SSID_EMPTY_MARK;
      endcase
      return k;
   endfunction

   // offer one word, hold it until taken, then log its expected response
   task automatic send_word(input logic [1:0] mode, input logic [11:0] addr,
                            input logic [63:0] value, input bit typed,
                            input rsp_word_type typed_rsp);
      rsp_word_type predicted;
      req_valid   <= 1'b1;
      req_mode    <= mode;
      req_address <= addr;
      req_value   <= value;
      @(posedge clock);
      while (req_stall !== 1'b0) @(posedge clock);
      predicted = segment_update(mode, addr, value);
      expected_rsp.push_back(typed ? typed_rsp : predicted);
      sent_count++;
      if (!quiet && $urandom_range(0, 3) == 0) begin
         req_valid <= 1'b0;
         repeat ($urandom_range(1, 12)) @(posedge clock);
      end
   endtask

   task automatic send_plain(input logic [1:0] mode, input logic [11:0] addr,
                             input logic [63:0] value);
      send_word(mode, addr, value, 1'b0, '0);
   endtask

   // load a whole segment: sorted real keys, then empty markers
   task automatic fill_segment(input int head);
      logic [63:0] keys [$];
      int          n_real;
      n_real = $urandom_range(0, SEG_WORDS);
      for (int i = 0; i < n_real; i++) keys.push_back(random_key());
      keys.sort();
      for (int i = 0; i < SEG_WORDS; i++) begin
         send_plain(SSID_MODE_LOAD, 12'(head + i),
                    (i < n_real) ? keys[i] : SSID_EMPTY_MARK);
      end
      seg_heads.push_back(head);
   endtask

   // stimulus: reset, directed table, random traffic, drain
   initial begin
      int           pick;
      int           h;
      int           a;
      logic [63:0]  v;
      rsp_word_type typed_rsp;
      bit           drained;
      drained = 1'b0;
      repeat (4) @(posedge clock);
      reset <= 1'b0;

      foreach (directed_rows[i]) begin
         typed_rsp.read_data = directed_rows[i].exp_data;
         typed_rsp.status    = directed_rows[i].exp_status;
         send_word(directed_rows[i].mode, directed_rows[i].addr, directed_rows[i].value,
                   directed_rows[i].typed, typed_rsp);
      end
      seg_heads.push_back(MEM_WORDS - SEG_WORDS);

      while (sent_count < ITEM_TARGET) begin
         if (sent_count >= QUIET_FROM) quiet = 1'b1;
         // hold the sender until the block has answered everything
         if (!drained && sent_count >= DRAIN_AT) begin
            drained = 1'b1;
            req_valid <= 1'b0;
            while (expected_rsp.size() != 0) @(posedge clock);
         end
         pick = $urandom_range(0, 99);
         if (pick < 6) begin
            h = ($urandom_range(0, 1) == 0) ? 16 * $urandom_range(0, 15)
                                            : $urandom_range(0, MEM_WORDS - SEG_WORDS);
            fill_segment(h);
         end else if (pick < 50) begin
            v = random_key() | (($urandom_range(0, 1) == 0) ? '0 : SSID_EMPTY_MARK);
            send_plain(SSID_MODE_INSERT, 12'(pick_head()), v);
         end else if (pick < 78) begin
            h = pick_head();
            v = ($urandom_range(0, 2) != 0) ? mem_image[h + $urandom_range(0, SEG_WORDS - 1)]
                                            : random_key();
            v = v ^ (($urandom_range(0, 1) == 0) ? '0 : SSID_EMPTY_MARK);
            send_plain(SSID_MODE_DELETE, 12'(h), v);
         end else if (pick < 88) begin
            a = $urandom_range(0, MEM_WORDS - 1);
            if (!written[a]) a = pick_head() + $urandom_range(0, SEG_WORDS - 1);
            send_plain(SSID_MODE_READ, 12'(a), {$urandom(), $urandom()});
         end else if (pick < 94) begin
            send_plain(SSID_MODE_LOAD, 12'($urandom_range(0, MEM_WORDS - 1)),
                       {$urandom(), $urandom()});
         end else begin
            send_plain(($urandom_range(0, 1) == 0) ? SSID_MODE_INSERT : SSID_MODE_DELETE,
                       12'($urandom_range(MEM_WORDS - SEG_WORDS + 1, MEM_WORDS - 1)),
                       {$urandom(), $urandom()});
         end
      end

      // drain, then allow one full update time for stray words
      req_valid <= 1'b0;
      while (expected_rsp.size() != 0) @(posedge clock);
      repeat (2 * SEG_WORDS + 8) @(posedge clock);
      if (error_count == 0) begin
         $display("== PASS ==");
      end else begin
         $display("== FAIL ==");
      end
      $finish;
   end

   // response side: one long hold-off, random stall bursts, none near the end
   initial begin
      bit held;
      held = 1'b0;
      while (reset) @(posedge clock);
      forever begin
         @(posedge clock);
         if (!held && sent_count >= HOLD_AT) begin
            held = 1'b1;
            rsp_stall <= 1'b1;
            repeat (HOLD_CYCLES) @(posedge clock);
            rsp_stall <= 1'b0;
         end else if (!quiet && $urandom_range(0, 7) == 0) begin
            rsp_stall <= 1'b1;
            repeat ($urandom_range(1, 12)) @(posedge clock);
            rsp_stall <= 1'b0;
         end
      end
   end

   // compare each accepted response word with the oldest expectation
   always @(posedge clock) begin
      rsp_word_type want;
      if (!reset && rsp_valid === 1'b1 && rsp_stall === 1'b0) begin
         if (expected_rsp.size() == 0) begin
            $display("%0t: unexpected response word: read_data %h status %0d",
                     $time, rsp_read_data, rsp_status);
            error_count++;
         end else begin
            want = expected_rsp.pop_front();
            if (rsp_read_data !== want.read_data) begin
               $display("%0t: read_data mismatch: expected %h, actual %h",
                        $time, want.read_data, rsp_read_data);
               error_count++;
            end
            if (rsp_status !== want.status) begin
               $display("%0t: status mismatch: expected %0d, actual %0d",
                        $time, want.status, rsp_status);
               error_count++;
            end
         end
      end
   end

   // watchdog
   always @(posedge clock) begin
      cycle_count++;
      if (cycle_count > CYCLE_LIMIT) begin
         $display("%0t: timeout with %0d responses outstanding", $time, expected_rsp.size());
         $display("== FAIL ==");
         $finish;
      end
   end

endmodule

// ===== filelist.f =====
rtl/ssid_pkg.sv
rtl/ssid_ram.sv
rtl/ssid_cell.sv
rtl/sorted_segment_insert_delete.sv
verif/tb_sorted_segment_insert_delete.sv
